[rtl/core/tpjm_pkg.sv]
// Shared types, widths and codes of the tick period jitter monitor.
// Used by every module of the block but tpjm_cell; depends on nothing.
`default_nettype none

package tpjm_pkg;

  // Field widths
  localparam int STAMP_W    = 64;
  localparam int PERIOD_W   = 40;
  localparam int NOM_W      = 32;
  localparam int TOL_W      = 8;
  localparam int STAT_W     = 2;
  localparam int LIMIT_W    = NOM_W + TOL_W + 1;
  localparam int CMP_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Default ring depth, a power of two from 2 to 256
  localparam int RING_DEPTH_DEF = 16;

  // Reset value of the tolerance register
  localparam logic [TOL_W-1:0] TOL_RESET = 8'd64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RESET   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ERROR   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RESTART = 2'd3;

  // Request types
  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REFILL,
    S_ACCUM,
    S_CHECK,
    S_DONE
  } state_t;

  // Control from the sequencer to the period chain
  typedef struct packed {
    logic shift;  // advance every cell by one place
    logic fill;   // feed the nominal period instead of the new period
  } ring_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/tpjm_cell.sv]
// One cell of the period chain: holds one stored period.
// Uses no package items; instantiated by tpjm_ring.
`default_nettype none

module tpjm_cell #(
  parameter int W = 40
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         shift,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] val_r;

  // Take the neighbor's value on each shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (shift) begin
      val_r <= d;
    end
  end

  assign q = val_r;

endmodule

`default_nettype wire

[rtl/core/tpjm_ring.sv]
// Chain of period cells: newest period enters at cell 0, oldest leaves the last cell.
// Depends on tpjm_pkg and tpjm_cell.
`default_nettype none

module tpjm_ring #(
  parameter int RING_DEPTH = tpjm_pkg::RING_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire tpjm_pkg::ring_ctrl_t            ctrl,
  input  wire logic [tpjm_pkg::PERIOD_W-1:0]   period,
  input  wire logic [tpjm_pkg::NOM_W-1:0]      nominal,
  output logic      [tpjm_pkg::PERIOD_W-1:0]   oldest
);

  logic [tpjm_pkg::PERIOD_W-1:0] din;
  logic [tpjm_pkg::PERIOD_W-1:0] tap [RING_DEPTH];

  // Select what enters the chain
  assign din = ctrl.fill ? tpjm_pkg::PERIOD_W'(nominal) : period;

  // Build the chain, each cell fed by its left neighbor
  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      tpjm_cell #(.W(tpjm_pkg::PERIOD_W)) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (ctrl.shift),
        .d     (din),
        .q     (tap[i])
      );
    end else begin : g_body
      tpjm_cell #(.W(tpjm_pkg::PERIOD_W)) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (ctrl.shift),
        .d     (tap[i-1]),
        .q     (tap[i])
      );
    end
  end

  assign oldest = tap[RING_DEPTH-1];

endmodule

`default_nettype wire

[rtl/core/tick_period_jitter_monitor_unit.sv]
// Top level of the tick period jitter monitor: sequencer, timing state and result register.
// Depends on tpjm_pkg and tpjm_ring (which uses tpjm_cell).
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in_     | input     | in_valid / in_ready    | in_req_type, in_timestamp
//  out_    | output    | out_valid / out_ready  | out_status, out_late_amount,
//          |           |                        | out_elapsed_time, out_last_time
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A restart passes S_EXEC and S_DONE, a continuing tick without the check S_EXEC, S_ACCUM
// and S_DONE, a checked tick S_CHECK as well. A tick that opens a new run with the check
// enabled refills the period chain in S_REFILL, one cell per cycle. in_ready is high
// only in S_IDLE and rises again once the result is in the output register.
// Reset (rst_n low, synchronous) empties the last timestamp, clears elapsed time, the
// chain and the sum, and loads the register defaults. A stalled result holds in the
// output register; the next request is taken meanwhile and waits in its final state.
// cfg_ready is always high.
`default_nettype none

module tick_period_jitter_monitor_unit #(
  parameter int RING_DEPTH = tpjm_pkg::RING_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // request channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_req_type,
  input  wire logic [tpjm_pkg::STAMP_W-1:0]        in_timestamp,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [tpjm_pkg::STAT_W-1:0]         out_status,
  output logic      [tpjm_pkg::PERIOD_W-1:0]       out_late_amount,
  output logic      [tpjm_pkg::STAMP_W-1:0]        out_elapsed_time,
  output logic      [tpjm_pkg::STAMP_W-1:0]        out_last_time,
  // configuration channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tpjm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tpjm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int LOG2D = $clog2(RING_DEPTH);
  localparam int SUM_W = tpjm_pkg::PERIOD_W + LOG2D;
  localparam logic [LOG2D-1:0] CNT_LAST = LOG2D'(RING_DEPTH - 1);

  // Configuration registers
  logic [tpjm_pkg::NOM_W-1:0]    nominal_r;
  logic [tpjm_pkg::TOL_W-1:0]    tol_r;
  logic                          en_r;

  // Sequencer
  tpjm_pkg::state_t              state_r, state_nxt;
  logic [LOG2D-1:0]              cnt_r;

  // Request and timing state
  logic                          req_r;
  logic [tpjm_pkg::STAMP_W-1:0]  stamp_r;
  logic [tpjm_pkg::STAMP_W-1:0]  last_r;
  logic [tpjm_pkg::STAMP_W-1:0]  elapsed_r;
  logic [tpjm_pkg::PERIOD_W-1:0] period_r;
  logic [SUM_W-1:0]              sum_r;
  logic [tpjm_pkg::LIMIT_W-1:0]  limit_r;
  logic [tpjm_pkg::STAT_W-1:0]   status_r;
  logic [tpjm_pkg::PERIOD_W-1:0] late_r;

  // Result register
  logic                          out_valid_r;
  logic [tpjm_pkg::STAT_W-1:0]   out_status_r;
  logic [tpjm_pkg::PERIOD_W-1:0] out_late_r;
  logic [tpjm_pkg::STAMP_W-1:0]  out_elapsed_r;
  logic [tpjm_pkg::STAMP_W-1:0]  out_last_r;

  // Datapath nets
  logic                          in_fire, cfg_fire, out_load;
  tpjm_pkg::ring_ctrl_t          ring_ctrl;
  logic [tpjm_pkg::PERIOD_W-1:0] oldest;
  logic [tpjm_pkg::STAMP_W:0]    diff;
  logic [tpjm_pkg::PERIOD_W-1:0] period_sat;
  logic [tpjm_pkg::STAMP_W:0]    elapsed_sum;
  logic [tpjm_pkg::CMP_W-1:0]    sum_scaled, limit_scaled;
  logic                          over;
  logic [tpjm_pkg::PERIOD_W-1:0] nominal_ext;

  assign in_fire  = in_valid && in_ready;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign cfg_ready = 1'b1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tpjm_pkg::S_IDLE: begin
        if (in_valid) state_nxt = tpjm_pkg::S_EXEC;
      end
      tpjm_pkg::S_EXEC: begin
        if (req_r == tpjm_pkg::REQ_RESTART) begin
          state_nxt = tpjm_pkg::S_DONE;
        end else if (last_r == '0) begin
          state_nxt = en_r ? tpjm_pkg::S_REFILL : tpjm_pkg::S_DONE;
        end else begin
          state_nxt = tpjm_pkg::S_ACCUM;
        end
      end
      tpjm_pkg::S_REFILL: begin
        if (cnt_r == CNT_LAST) state_nxt = tpjm_pkg::S_DONE;
      end
      tpjm_pkg::S_ACCUM: begin
        state_nxt = en_r ? tpjm_pkg::S_CHECK : tpjm_pkg::S_DONE;
      end
      tpjm_pkg::S_CHECK: begin
        state_nxt = tpjm_pkg::S_DONE;
      end
      tpjm_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = tpjm_pkg::S_IDLE;
      end
      default: state_nxt = tpjm_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready       = 1'b0;
    out_load       = 1'b0;
    ring_ctrl.shift = 1'b0;
    ring_ctrl.fill  = 1'b0;
    case (state_r)
      tpjm_pkg::S_IDLE:   in_ready = 1'b1;
      tpjm_pkg::S_REFILL: begin
        ring_ctrl.shift = 1'b1;
        ring_ctrl.fill  = 1'b1;
      end
      tpjm_pkg::S_ACCUM:  ring_ctrl.shift = en_r;
      tpjm_pkg::S_DONE:   out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpjm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Period chain
  tpjm_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ring_ctrl),
    .period  (period_r),
    .nominal (nominal_r),
    .oldest  (oldest)
  );

  // Period since the last stamp: zero when time runs backwards, saturate at 40 bits
  assign diff = {1'b0, stamp_r} - {1'b0, last_r};
  always_comb begin
    if (diff[tpjm_pkg::STAMP_W]) begin
      period_sat = '0;
    end else if (|diff[tpjm_pkg::STAMP_W-1:tpjm_pkg::PERIOD_W]) begin
      period_sat = '1;
    end else begin
      period_sat = diff[tpjm_pkg::PERIOD_W-1:0];
    end
  end

  assign elapsed_sum = {1'b0, elapsed_r} + {25'd0, period_r};

  // Average check: sum * 256 against limit * depth, both exact
  assign sum_scaled   = tpjm_pkg::CMP_W'({sum_r, 8'd0});
  assign limit_scaled = tpjm_pkg::CMP_W'({limit_r, LOG2D'(0)});
  assign over         = sum_scaled > limit_scaled;
  assign nominal_ext  = tpjm_pkg::PERIOD_W'(nominal_r);

  // Configuration and timing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nominal_r <= '0;
      tol_r     <= tpjm_pkg::TOL_RESET;
      en_r      <= 1'b0;
      last_r    <= '0;
      elapsed_r <= '0;
      sum_r     <= '0;
      cnt_r     <= '0;
    end else begin
      case (state_r)
        tpjm_pkg::S_EXEC: begin
          cnt_r <= '0;
          if (req_r == tpjm_pkg::REQ_RESTART) begin
            last_r <= '0;
          end else begin
            last_r <= stamp_r;
            if (last_r == '0) begin
              elapsed_r <= '0;
              if (en_r) sum_r <= SUM_W'(nominal_r) << LOG2D;
            end
          end
        end
        tpjm_pkg::S_REFILL: cnt_r <= cnt_r + 1'b1;
        tpjm_pkg::S_ACCUM: begin
          elapsed_r <= elapsed_sum[tpjm_pkg::STAMP_W] ? '1
                                                      : elapsed_sum[tpjm_pkg::STAMP_W-1:0];
          if (en_r) sum_r <= sum_r + SUM_W'(period_r) - SUM_W'(oldest);
        end
        default: ;
      endcase
      // Register writes; a new nominal or enable starts a new run
      if (cfg_fire) begin
        case (cfg_index)
          tpjm_pkg::CFG_NOMINAL: begin
            nominal_r <= cfg_data[tpjm_pkg::NOM_W-1:0];
            last_r    <= '0;
          end
          tpjm_pkg::CFG_TOL:    tol_r <= cfg_data[tpjm_pkg::TOL_W-1:0];
          tpjm_pkg::CFG_ENABLE: begin
            en_r   <= cfg_data[0];
            last_r <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Request capture, period, limit and status
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r   <= in_req_type;
      stamp_r <= in_timestamp;
    end
    case (state_r)
      tpjm_pkg::S_EXEC: begin
        period_r <= period_sat;
        limit_r  <= tpjm_pkg::LIMIT_W'(nominal_r)
                    * tpjm_pkg::LIMIT_W'({1'b0, tol_r} + 9'd256);
        late_r   <= '0;
        if (req_r == tpjm_pkg::REQ_RESTART) begin
          status_r <= tpjm_pkg::STAT_RESTART;
        end else if (last_r == '0) begin
          status_r <= tpjm_pkg::STAT_RESET;
        end else begin
          status_r <= tpjm_pkg::STAT_OK;
        end
      end
      tpjm_pkg::S_CHECK: begin
        if (over) begin
          status_r <= tpjm_pkg::STAT_ERROR;
          late_r   <= (period_r > nominal_ext) ? period_r - nominal_ext : '0;
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r  <= status_r;
      out_late_r    <= late_r;
      out_elapsed_r <= elapsed_r;
      out_last_r    <= last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_late_amount  = out_late_r;
  assign out_elapsed_time = out_elapsed_r;
  assign out_last_time    = out_last_r;

endmodule

`default_nettype wire

[rtl/core/tpjm_checker.sv]
// Port-level checks of the tick period jitter monitor, bound to the top level.
// Depends on tpjm_pkg and tick_period_jitter_monitor_unit.
`default_nettype none

module tpjm_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [tpjm_pkg::STAT_W-1:0]       out_status,
  input wire logic [tpjm_pkg::PERIOD_W-1:0]     out_late_amount,
  input wire logic [tpjm_pkg::STAMP_W-1:0]      out_elapsed_time,
  input wire logic [tpjm_pkg::STAMP_W-1:0]      out_last_time
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_last_time))
    else $error("stalled result changed");

  // One request at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // Late amount only on an error
  a_late_only_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != tpjm_pkg::STAT_ERROR |-> out_late_amount == '0)
    else $error("late amount without error");

  // A restart empties the stored stamp
  a_restart_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == tpjm_pkg::STAT_RESTART |-> out_last_time == '0)
    else $error("restart left a stamp");

  // A new run starts with elapsed time cleared
  a_reset_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == tpjm_pkg::STAT_RESET |-> out_elapsed_time == '0)
    else $error("new run kept elapsed time");

endmodule

bind tick_period_jitter_monitor_unit tpjm_checker u_tpjm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_late_amount  (out_late_amount),
  .out_elapsed_time (out_elapsed_time),
  .out_last_time    (out_last_time)
);

`default_nettype wire

[test/tick_period_jitter_monitor_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for tick_period_jitter_monitor_unit: directed table then random runs.
// Depends on tpjm_pkg and the block's RTL; predicts every result in-line and compares, typed rows against the table.

module tick_period_jitter_monitor_unit_tb;
  import tpjm_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int RING_DEPTH = RING_DEPTH_DEF;
  localparam int TOTAL_REQUESTS = 2000;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int END_SETTLE = RING_DEPTH + 16;
  localparam int PRESSURE_AT = 150;
  localparam int PRESSURE_CYCLES = 400;
  localparam int PRINT_CAP = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [STAMP_W-1:0] PERIOD_SAT = (64'd1 << PERIOD_W) - 64'd1;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [PERIOD_W-1:0] late;
    logic [STAMP_W-1:0]  elapsed;
    logic [STAMP_W-1:0]  last;
  } tick_report_t;

  // One line of the directed table: a register write or a request
  typedef struct packed {
    logic                 is_cfg;
    logic                 req;
    logic [STAMP_W-1:0]   word;
    logic [CFG_IDX_W-1:0] idx;
    logic                 typed;
    tick_report_t         want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_req_type;
  logic [STAMP_W-1:0] in_timestamp;
  logic out_valid;
  logic out_ready;
  logic [STAT_W-1:0] out_status;
  logic [PERIOD_W-1:0] out_late_amount;
  logic [STAMP_W-1:0] out_elapsed_time;
  logic [STAMP_W-1:0] out_last_time;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Typed expectation riding along with the request it belongs to
  logic row_typed;
  tick_report_t row_want;

  // Predictor copy of registers and timing state
  logic [NOM_W-1:0]    p_nominal;
  logic [TOL_W-1:0]    p_tol;
  logic                p_check;
  logic [STAMP_W-1:0]  p_last_stamp;
  logic [STAMP_W-1:0]  p_elapsed;
  logic [PERIOD_W-1:0] p_ring [RING_DEPTH];
  int                  p_head;
  logic [STAMP_W-1:0]  p_sum;

  tick_report_t pending_reports[$];
  stim_row_t directed_rows[$];
  int sent_count = 0;
  int reports_done = 0;
  int err_count = 0;
  int cycle_count = 0;
  bit cfg_open = 1'b0;

  tick_period_jitter_monitor_unit #(
    .RING_DEPTH(RING_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_timestamp(in_timestamp),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_late_amount(out_late_amount),
    .out_elapsed_time(out_elapsed_time),
    .out_last_time(out_last_time),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tick_period_jitter_monitor_unit test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [STAMP_W-1:0] got,
                             input logic [STAMP_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                reports_done, name, got, want));
  endtask

  // Load every ring slot with the nominal period and restart the head
  task automatic refill_periods();
    for (int i = 0; i < RING_DEPTH; i++) p_ring[i] = PERIOD_W'(p_nominal);
    p_sum = 64'(p_nominal) * RING_DEPTH;
    p_head = 0;
  endtask

  // Advance the timing state by one request and build its report
  task automatic predict_report(input logic rt, input logic [STAMP_W-1:0] ts,
                                output tick_report_t rep);
    logic [STAMP_W-1:0] prev;
    logic [STAMP_W-1:0] period;
    logic [STAMP_W-1:0] limit;
    rep.status = STAT_OK;
    rep.late = '0;
    if (rt == REQ_RESTART) begin
      p_last_stamp = '0;
      rep.status = STAT_RESTART;
    end else begin
      prev = p_last_stamp;
      p_last_stamp = ts;
      if (prev == '0) begin
        // empty store opens a new run
        p_elapsed = '0;
        if (p_check) refill_periods();
        rep.status = STAT_RESET;
      end else begin
        period = '0;
        if (ts >= prev) begin
          period = ts - prev;
          if (period > PERIOD_SAT) period = PERIOD_SAT;
        end
        if (p_elapsed > STAMP_MAX - period) p_elapsed = STAMP_MAX;
        else p_elapsed = p_elapsed + period;
        if (p_check) begin
          p_head = (p_head + 1) % RING_DEPTH;
          p_sum = p_sum + period - 64'(p_ring[p_head]);
          p_ring[p_head] = period[PERIOD_W-1:0];
          limit = 64'(p_nominal) * (64'd256 + 64'(p_tol)) * RING_DEPTH;
          if ((p_sum << 8) > limit) begin
            rep.status = STAT_ERROR;
            if (period > 64'(p_nominal)) rep.late = PERIOD_W'(period - 64'(p_nominal));
          end
        end
      end
    end
    rep.elapsed = p_elapsed;
    rep.last = p_last_stamp;
  endtask

  // Track register writes, predict on each request, check each result
  always @(posedge clk) begin : scoreboard
    tick_report_t predicted;
    tick_report_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NOMINAL: begin
            p_nominal = cfg_data[NOM_W-1:0];
            p_last_stamp = '0;
          end
          CFG_TOL: p_tol = cfg_data[TOL_W-1:0];
          CFG_ENABLE: begin
            p_check = cfg_data[0];
            p_last_stamp = '0;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_report(in_req_type, in_timestamp, predicted);
        pending_reports.push_back(row_typed ? row_want : predicted);
      end
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request outstanding", reports_done));
        end else begin
          want = pending_reports.pop_front();
          check_field("status", 64'(out_status), 64'(want.status));
          check_field("late_amount", 64'(out_late_amount), 64'(want.late));
          check_field("elapsed_time", out_elapsed_time, want.elapsed);
          check_field("last_time", out_last_time, want.last);
        end
        reports_done++;
      end
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Result sink: random stalls, calm stretches and one long hold-off
  initial begin : result_sink
    int hold;
    int calm;
    int taken;
    bit pressure_done;
    out_ready = 1'b0;
    hold = 0;
    calm = 0;
    taken = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (!pressure_done && taken >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold = PRESSURE_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (calm > 0) begin
        calm--;
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        calm = $urandom_range(50, 300);
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        hold = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_req(input logic rt, input logic [STAMP_W-1:0] ts, input logic typed,
                         input logic [STAT_W-1:0] st, input logic [PERIOD_W-1:0] late,
                         input logic [STAMP_W-1:0] el, input logic [STAMP_W-1:0] last);
    stim_row_t row;
    row = '0;
    row.req = rt;
    row.word = ts;
    row.typed = typed;
    row.want.status = st;
    row.want.late = late;
    row.want.elapsed = el;
    row.want.last = last;
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.word = 64'(data);
    directed_rows.push_back(row);
  endtask

  // Hold a register write until taken; valid stays up for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    cfg_open = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Offer one request and hold it until accepted
  task automatic send_req(input logic rt, input logic [STAMP_W-1:0] ts, input logic typed,
                          input tick_report_t want);
    if (cfg_open) begin
      cfg_valid <= 1'b0;
      cfg_open = 1'b0;
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_timestamp <= ts;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic rest(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop the request line and wait until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (reports_done < sent_count) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [NOM_W-1:0] nom;
    logic [TOL_W-1:0] tol;
    logic [STAMP_W-1:0] cur;
    logic [STAMP_W-1:0] ts;
    longint per;
    int bias;
    int r;
    int count;
    bit calm_phase;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_TICK;
    in_timestamp = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NOMINAL;
    cfg_data = '0;
    row_typed = 1'b0;
    row_want = '0;
    p_nominal = '0;
    p_tol = TOL_RESET;
    p_check = 1'b0;
    p_last_stamp = '0;
    p_elapsed = '0;
    refill_periods();

    // Defaults: check off, nominal zero
    add_req(REQ_TICK, 64'd100, 1, STAT_RESET, 0, 0, 64'd100);
    add_req(REQ_TICK, 64'd300, 1, STAT_OK, 0, 64'd200, 64'd300);
    add_req(REQ_TICK, 64'd50, 1, STAT_OK, 0, 64'd200, 64'd50);
    add_req(REQ_TICK, STAMP_MAX, 1, STAT_OK, 0, 64'h100_0000_00C7, STAMP_MAX);
    add_req(REQ_RESTART, STAMP_MAX, 1, STAT_RESTART, 0, 64'h100_0000_00C7, 64'd0);
    add_req(REQ_TICK, 64'd0, 1, STAT_RESET, 0, 0, 64'd0);
    add_req(REQ_TICK, 64'd5, 1, STAT_RESET, 0, 0, 64'd5);
    add_req(REQ_TICK, 64'd5, 1, STAT_OK, 0, 0, 64'd5);
    add_req(REQ_TICK, 64'h8000_0000_0000_0000, 1, STAT_OK, 0, PERIOD_SAT,
            64'h8000_0000_0000_0000);
    // Check on, zero tolerance: average exactly nominal passes, one unit over fails
    add_cfg(CFG_NOMINAL, 32'd1000);
    add_cfg(CFG_TOL, 32'd0);
    add_cfg(CFG_ENABLE, 32'd1);
    add_cfg(CFG_UNUSED, 32'hFFFF_FFFF);
    add_req(REQ_TICK, 64'd1000, 1, STAT_RESET, 0, 0, 64'd1000);
    add_req(REQ_TICK, 64'd2000, 1, STAT_OK, 0, 64'd1000, 64'd2000);
    add_req(REQ_TICK, 64'd3001, 1, STAT_ERROR, 40'd1, 64'd2001, 64'd3001);
    add_req(REQ_TICK, 64'd3001, 1, STAT_OK, 0, 64'd2001, 64'd3001);
    // Tolerance change keeps the run going
    add_cfg(CFG_TOL, 32'd255);
    add_req(REQ_TICK, 64'd100000, 0, STAT_OK, 0, 0, 0);
    // Largest nominal, saturated period
    add_cfg(CFG_NOMINAL, 32'hFFFF_FFFF);
    add_req(REQ_TICK, 64'd1, 1, STAT_RESET, 0, 0, 64'd1);
    add_req(REQ_TICK, STAMP_MAX, 0, STAT_OK, 0, 0, 0);
    add_req(REQ_TICK, STAMP_MAX, 0, STAT_OK, 0, 0, 0);
    add_req(REQ_RESTART, 64'd0, 0, STAT_OK, 0, 0, 0);
    // Check off again: time going backwards reads as zero period
    add_cfg(CFG_ENABLE, 32'd0);
    add_req(REQ_TICK, 64'd7, 1, STAT_RESET, 0, 0, 64'd7);
    add_req(REQ_TICK, 64'd6, 1, STAT_OK, 0, 0, 64'd6);
    // Nominal zero with the check on: any positive average is late
    add_cfg(CFG_NOMINAL, 32'd0);
    add_cfg(CFG_TOL, 32'd64);
    add_cfg(CFG_ENABLE, 32'd1);
    add_req(REQ_TICK, 64'd10, 1, STAT_RESET, 0, 0, 64'd10);
    add_req(REQ_TICK, 64'd11, 1, STAT_ERROR, 40'd1, 64'd1, 64'd11);
    add_req(REQ_TICK, 64'd11, 1, STAT_ERROR, 40'd0, 64'd1, 64'd11);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        if (!cfg_open) drain_results();
        write_reg(directed_rows[i].idx, directed_rows[i].word[CFG_DATA_W-1:0]);
      end else begin
        send_req(directed_rows[i].req, directed_rows[i].word, directed_rows[i].typed,
                 directed_rows[i].want);
        rest(pick_gap());
      end
    end

    // Random runs: reprogram while idle, then mostly steady ticks around the nominal period
    nom = '0;
    tol = 8'd64;
    cur = {$urandom, $urandom};
    while (sent_count < TOTAL_REQUESTS) begin
      drain_results();
      r = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) begin
        tol = 8'($urandom);
        write_reg(CFG_TOL, 32'(tol));
      end else begin
        if (r == 0) nom = '0;
        else if (r == 1) nom = '1;
        else if (r < 5) nom = $urandom_range(1, 5000);
        else nom = $urandom;
        r = $urandom_range(0, 6);
        tol = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom);
        cur = {$urandom, $urandom};
        write_reg(CFG_NOMINAL, 32'(nom));
        write_reg(CFG_TOL, 32'(tol));
        write_reg(CFG_ENABLE, ($urandom_range(0, 4) == 0) ? 32'd0 : 32'd1);
        if ($urandom_range(0, 4) == 0) write_reg(CFG_UNUSED, $urandom);
      end
      bias = int'($urandom_range(0, 2 * int'(tol) + 40)) - 20;
      calm_phase = ($urandom_range(0, 4) == 0);
      count = $urandom_range(60, 200);
      repeat (count) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          send_req(REQ_RESTART, {$urandom, $urandom}, 1'b0, '0);
        end else begin
          if (r < 5) begin
            ts = '0;
          end else if (r < 8) begin
            ts = cur - 64'($urandom_range(1, 1000000));
          end else if (r < 10) begin
            ts = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom}
                                              : cur + {8'd0, 24'($urandom), $urandom};
          end else begin
            per = longint'(nom) +
                  (longint'(nom) * (bias + int'($urandom_range(0, 64)) - 32)) / 256;
            if (nom == '0) per = $urandom_range(0, 100);
            if (per < 0) per = 0;
            ts = cur + 64'(per);
          end
          cur = ts;
          send_req(REQ_TICK, ts, 1'b0, '0);
        end
        rest(calm_phase ? 0 : pick_gap());
      end
    end

    drain_results();
    repeat (END_SETTLE) @(posedge clk);
    if (pending_reports.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_reports.size()));
    if (err_count == 0) begin
      $display("tick_period_jitter_monitor_unit test passed");
    end else begin
      $display("tick_period_jitter_monitor_unit test failed");
    end
    $finish;
  end

endmodule
